/* hw/rtl/bgd_pkg.sv */
// ---------------------------------------------------------------------------
// bgd_pkg: shared types and helpers for the GRBG demosaic
// Sizes, opcode and register index codes, the 3x3 window and the
// per-pixel site flags passed from the line stage to the interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

  localparam int MaxWidth    = 4096;
  localparam int HeightLimit = 4096;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int DimW        = 13;
  localparam int PixW        = 8;
  localparam int CntW        = ((ColW > DimW) ? ColW : DimW) + 1;

  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // Input item kinds (carried on tuser)
  localparam logic OpPixel = 1'b0;
  localparam logic OpFlush = 1'b1;

  // Configuration register indexes
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic [PixW-1:0] ul;
    logic [PixW-1:0] u;
    logic [PixW-1:0] ur;
    logic [PixW-1:0] l;
    logic [PixW-1:0] ce;
    logic [PixW-1:0] rt;
    logic [PixW-1:0] dl;
    logic [PixW-1:0] d;
    logic [PixW-1:0] dr;
  } win_t;

  typedef struct packed {
    logic y_odd;
    logic x_odd;
    logic x_first;
    logic y_first;
    logic x_last;
    logic y_last;
  } site_t;

  function automatic logic [PixW-1:0] avg2(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b);
    logic [PixW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      return s[PixW:1];
    end
  endfunction

  // Clamp to [2, limit] and round down to even
  function automatic logic [DimW-1:0] eff_size(input logic [DimW-1:0] v,
                                               input int limit);
    logic [DimW-1:0] t;
    begin
      t = v;
      if (t < DimW'(2)) t = DimW'(2);
      if (int'(t) > limit) t = DimW'(limit);
      return t & ~DimW'(1);
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bgd_interp.sv */
// ---------------------------------------------------------------------------
// bgd_interp: bilinear color fill for one GRBG site
// Picks the missing colors from the 3x3 window as floor averages of two
// neighbors, one-sided at the frame edges.
// ---------------------------------------------------------------------------
`default_nettype none

module bgd_interp (
  input  var bgd_pkg::win_t              win,
  input  var bgd_pkg::site_t             site,
  output logic [bgd_pkg::PixW-1:0]       blue,
  output logic [bgd_pkg::PixW-1:0]       green,
  output logic [bgd_pkg::PixW-1:0]       red
);
  import bgd_pkg::*;

  always_comb begin
    if (!site.y_odd) begin
      if (!site.x_odd) begin
        // green on a G/R row
        blue  = site.y_first ? win.d : avg2(win.d, win.u);
        green = win.ce;
        red   = site.x_first ? win.rt : avg2(win.rt, win.l);
      end else begin
        // red site: left and down greens
        blue  = site.x_last ? win.dl : avg2(win.dr, win.dl);
        green = avg2(win.l, win.d);
        red   = win.ce;
      end
    end else begin
      if (!site.x_odd) begin
        // blue site: right and up greens
        blue  = win.ce;
        green = avg2(win.rt, win.u);
        red   = site.x_first ? win.ur : avg2(win.ul, win.ur);
      end else begin
        // green on a B/G row
        blue  = site.x_last ? win.l : avg2(win.rt, win.l);
        green = win.ce;
        red   = site.y_last ? win.u : avg2(win.d, win.u);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bayer_grbg_demosaic.sv */
// ---------------------------------------------------------------------------
// bayer_grbg_demosaic: GRBG Bayer to BGR, bilinear, one pixel per clock when the output is not stalled
// Two line stores and a 3x3 window give each pixel its neighbors.
// ---------------------------------------------------------------------------
// Throughput: one input transfer per clock while the output is not stalled by
//   out_tready, bounded by the single read and write port of each line store.
// Result path: the result for pixel (y,x) is released by the input transfer of
//   position (y+1,x+1) and passes through the line-store read register, then
//   the result register, before it shows on out_tvalid.
// Reset (rst_n low, synchronous): positions, window and valids clear, width
//   640, height 480. Line stores are not cleared and need no clearing pass.
`default_nettype none

module bayer_grbg_demosaic (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bgd_pkg::PixW-1:0]     in_tdata,   // [7:0] raw_pixel
  input  logic                         in_tuser,   // [0] opcode
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [3*bgd_pkg::PixW-1:0]   out_tdata,  // [7:0] blue, [15:8] green, [23:16] red
  output logic                         out_tlast,  // frame_last
  // configuration
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bgd_pkg::DimW-1:0]     cfg_wdata
);
  import bgd_pkg::*;

  // ---- configuration: keep the effective (clamped, even) sizes --------------
  logic [DimW-1:0] w_r, h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= eff_size(WidthReset, MaxWidth);
      h_r <= eff_size(HeightReset, HeightLimit);
    end else if (cfg_we) begin
      case (cfg_index)
        CfgWidth:  w_r <= eff_size(cfg_wdata, MaxWidth);
        CfgHeight: h_r <= eff_size(cfg_wdata, HeightLimit);
        default:   ;
      endcase
    end
  end

  // ---- input stage: position tracking and site decode -----------------------
  logic [ColW-1:0] col_r, col_nxt;
  logic [DimW-1:0] row_r, row_nxt;

  logic            acc;        // input transfer
  logic            take;       // transfer that does work
  logic            ignore;     // early flush: accepted, dropped
  logic            row_past;   // all rows in, treat as flush
  logic            c_zero;
  logic            at_end;
  logic            emit;
  logic            frame_last;
  logic [PixW-1:0] sample;
  logic [DimW:0]   last_row;
  site_t           site;

  assign acc      = in_tvalid && in_tready;
  assign row_past = (row_r >= h_r);
  assign ignore   = (in_tuser == OpFlush) && !row_past;
  assign take     = acc && !ignore;
  assign sample   = ((in_tuser == OpFlush) || row_past) ? '0 : in_tdata;
  assign c_zero   = (col_r == '0);
  assign at_end   = (CntW'(col_r) == (CntW'(w_r) - CntW'(1)));

  // The result leaving now is for (row-1, col-1), or for the last column
  // of row-2 when the input sits in column 0.
  assign emit     = (row_r >= DimW'(2)) || ((row_r == DimW'(1)) && !c_zero);
  assign last_row = {1'b0, h_r} + {{DimW{1'b0}}, c_zero};

  always_comb begin
    site.y_odd   = c_zero ? row_r[0] : ~row_r[0];
    site.x_odd   = c_zero ? 1'b1 : ~col_r[0];
    site.x_first = (col_r == ColW'(1));
    site.x_last  = c_zero;
    site.y_first = c_zero ? (row_r == DimW'(2)) : (row_r == DimW'(1));
    site.y_last  = ({1'b0, row_r} == last_row);
  end

  assign frame_last = site.x_last && site.y_last;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (emit && frame_last) begin
        // frame done: rewind for the next frame
        col_nxt = '0;
        row_nxt = '0;
      end else if (at_end) begin
        col_nxt = '0;
        row_nxt = row_r + DimW'(1);
      end else begin
        col_nxt = col_r + ColW'(1);
      end
    end
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---- line stores ------------------------------------------------------------
  // The middle line is written on the transfer; the upper line takes the old
  // middle value in the window stage, once its registered read is back. Two items
  // in flight never share a column within a frame.
  logic [PixW-1:0] up_mem  [MaxWidth];
  logic [PixW-1:0] mid_mem [MaxWidth];
  logic [PixW-1:0] up_rd_r, mid_rd_r;

  // ---- window stage registers -------------------------------------------------
  logic            s1_valid_r;
  logic            s1_emit_r;
  logic            s1_last_r;
  site_t           s1_site_r;
  logic [ColW-1:0] s1_col_r;
  logic [PixW-1:0] s1_sample_r;
  logic            s1_go;
  logic            out_en;
  logic            out_valid_r;

  assign out_en    = !out_valid_r || out_tready;
  // a stage item without a result leaves without waiting on the output
  assign s1_go     = s1_valid_r && (out_en || !s1_emit_r);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (take) begin
      mid_mem[col_r] <= sample;
      up_rd_r        <= up_mem[col_r];
      mid_rd_r       <= mid_mem[col_r];
    end
    if (s1_go) begin
      up_mem[s1_col_r] <= mid_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_emit_r   <= emit;
      s1_last_r   <= frame_last;
      s1_site_r   <= site;
      s1_col_r    <= col_r;
      s1_sample_r <= sample;
    end
  end

  // ---- 3x3 window: keep the left and centre columns, the new right column comes from
  //      the line reads and the stage sample --------------------------------
  logic [PixW-1:0] wmid_r [3];
  logic [PixW-1:0] wrt_r  [3];
  win_t            win;

  always_comb begin
    win.ul = wmid_r[0];
    win.u  = wrt_r[0];
    win.ur = up_rd_r;
    win.l  = wmid_r[1];
    win.ce = wrt_r[1];
    win.rt = mid_rd_r;
    win.dl = wmid_r[2];
    win.d  = wrt_r[2];
    win.dr = s1_sample_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        wmid_r[i] <= '0;
        wrt_r[i]  <= '0;
      end
    end else if (s1_go) begin
      // advance the window by one column
      wmid_r[0] <= wrt_r[0];
      wmid_r[1] <= wrt_r[1];
      wmid_r[2] <= wrt_r[2];
      wrt_r[0]  <= up_rd_r;
      wrt_r[1]  <= mid_rd_r;
      wrt_r[2]  <= s1_sample_r;
    end
  end

  // ---- interpolation and result register --------------------------------------
  logic [PixW-1:0] blue, green, red;

  bgd_interp u_interp (
    .win   (win),
    .site  (s1_site_r),
    .blue  (blue),
    .green (green),
    .red   (red)
  );

  logic [3*PixW-1:0] out_data_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r && s1_emit_r) begin
      out_data_r <= {red, green, blue};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ---- assertions ---------------------------------------------------------------
  // The row count never runs past the drain row of the frame.
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, row_r} <= ({1'b0, h_r} + (DimW+1)'(1))))
    else $error("row counter ran past the end of the frame");

  // Delivering the last pixel of the frame rewinds the position.
  a_frame_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit && frame_last) |=> (col_r == '0) && (row_r == '0))
    else $error("position not rewound after the last pixel");

  // A register write abandons the frame in progress.
  a_cfg_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (col_r == '0) && (row_r == '0))
    else $error("position not rewound after a register write");

endmodule

`default_nettype wire
